// ===== rtl/lrpe_pkg.sv =====
// Shared types, codes and helper constants of the LR table parse engine.
package lrpe_pkg;

    // Default sizes of the parse tables and the state stack, and the reduction limit
    localparam int NUM_STATES_DEF       = 256;
    localparam int NUM_TERMINALS_DEF    = 64;
    localparam int NUM_NONTERMINALS_DEF = 64;
    localparam int NUM_RULES_DEF        = 256;
    localparam int STACK_DEPTH_DEF      = 256;
    localparam int MAX_REDUCTIONS_DEF   = 63;

    // Input item kinds
    typedef enum logic [2:0] {
        ACT_TOKEN    = 3'd0,
        ACT_WR_SHIFT = 3'd1,
        ACT_WR_RED   = 3'd2,
        ACT_WR_GOTO  = 3'd3,
        ACT_WR_RULE  = 3'd4,
        ACT_START    = 3'd5
    } lrpe_action_t;

    // Table entry kinds
    localparam logic [1:0] KIND_EMPTY  = 2'd0;
    localparam logic [1:0] KIND_VALUE  = 2'd1;
    localparam logic [1:0] KIND_ACCEPT = 2'd2;

    // Result events
    typedef enum logic [3:0] {
        EV_SHIFT     = 4'd0,
        EV_REDUCE    = 4'd1,
        EV_ACCEPT    = 4'd2,
        EV_NOENTRY   = 4'd3,
        EV_CONFLICT  = 4'd4,
        EV_UNDERFLOW = 4'd5,
        EV_OVERFLOW  = 4'd6,
        EV_EMPTY     = 4'd7,
        EV_CHAIN     = 4'd8
    } lrpe_event_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TOP,
        ST_LOOK,
        ST_DEC,
        ST_RULE,
        ST_BASE,
        ST_GOTO
    } lrpe_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic        item_take;
        logic        tok_load;
        logic        clr_stack;
        logic        rd_top;
        logic        rd_tables;
        logic        rd_rule;
        logic        rd_base;
        logic        rd_goto;
        logic        do_shift;
        logic        do_reduce;
        logic        emit;
        lrpe_event_t ev;
    } lrpe_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic       tok_bad;
        logic       top_bad;
        logic       sh_valid;
        logic [1:0] red_kind;
        logic       sp_full;
        logic       fin;
        logic       cnt_max;
        logic       rule_bad;
        logic       len_ge_sp;
        logic       lhs_bad;
        logic       base_bad;
        logic       goto_valid;
        logic       red_ovf;
        logic       out_free;
    } lrpe_status_t;

endpackage

// ===== rtl/lrpe_ctrl.sv =====
// Sequencer that walks each token through lookups, reductions and its final result.
module lrpe_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           action,
    input  lrpe_pkg::lrpe_status_t st,
    output lrpe_pkg::lrpe_cmd_t  cmd
);
    import lrpe_pkg::*;

    lrpe_state_t state_reg, state_next;
    logic        halted_reg, halted_next;
    logic        take;

    assign in_ready = (state_reg == ST_IDLE);
    assign take     = in_valid && in_ready;

    // Hold state and halt flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            halted_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            halted_reg <= halted_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take && action == ACT_TOKEN && !halted_reg)
                    state_next = ST_TOP;
            end
            ST_TOP:
                state_next = ST_LOOK;
            ST_LOOK:
            begin
                if (st.tok_bad || st.top_bad)
                begin
                    if (st.out_free)
                        state_next = ST_IDLE;
                end
                else
                    state_next = ST_DEC;
            end
            ST_DEC:
            begin
                if (!st.sh_valid && st.red_kind == KIND_EMPTY)
                begin
                    if (st.out_free)
                        state_next = ST_IDLE;
                end
                else if (st.sh_valid || st.red_kind == KIND_ACCEPT
                         || st.cnt_max || st.rule_bad)
                begin
                    if (st.out_free)
                        state_next = ST_IDLE;
                end
                else
                    state_next = ST_RULE;
            end
            ST_RULE:
            begin
                if (st.len_ge_sp)
                begin
                    if (st.out_free)
                        state_next = ST_IDLE;
                end
                else
                    state_next = ST_BASE;
            end
            ST_BASE:
            begin
                if (st.lhs_bad || st.base_bad)
                begin
                    if (st.out_free)
                        state_next = ST_IDLE;
                end
                else
                    state_next = ST_GOTO;
            end
            ST_GOTO:
            begin
                if (st.out_free)
                begin
                    if (!st.goto_valid || st.red_ovf)
                        state_next = ST_IDLE;
                    else
                        state_next = ST_TOP;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs: commands and halt flag
    always_comb
    begin
        cmd         = '0;
        cmd.ev      = EV_SHIFT;
        halted_next = halted_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.item_take = take;
                if (take && action == ACT_START)
                begin
                    cmd.clr_stack = 1'b1;
                    halted_next   = 1'b0;
                end
                if (take && action == ACT_TOKEN && !halted_reg)
                    cmd.tok_load = 1'b1;
            end
            ST_TOP:
                cmd.rd_top = 1'b1;
            ST_LOOK:
            begin
                if (st.tok_bad || st.top_bad)
                begin
                    cmd.ev = EV_NOENTRY;
                    if (st.out_free)
                    begin
                        cmd.emit    = 1'b1;
                        halted_next = 1'b1;
                    end
                end
                else
                    cmd.rd_tables = 1'b1;
            end
            ST_DEC:
            begin
                if (!st.sh_valid && st.red_kind == KIND_EMPTY)
                begin
                    cmd.ev   = EV_NOENTRY;
                    cmd.emit = st.out_free;
                    if (st.out_free)
                        halted_next = 1'b1;
                end
                else if (st.sh_valid && st.red_kind != KIND_EMPTY)
                begin
                    cmd.ev   = EV_CONFLICT;
                    cmd.emit = st.out_free;
                    if (st.out_free)
                        halted_next = 1'b1;
                end
                else if (st.red_kind == KIND_ACCEPT)
                begin
                    cmd.ev   = EV_ACCEPT;
                    cmd.emit = st.out_free;
                    if (st.out_free)
                        halted_next = 1'b1;
                end
                else if (st.sh_valid)
                begin
                    // push the shift target unless the stack is full
                    if (st.sp_full)
                        cmd.ev = EV_OVERFLOW;
                    else if (st.fin)
                        cmd.ev = EV_UNDERFLOW;
                    else
                        cmd.ev = EV_SHIFT;
                    cmd.emit     = st.out_free;
                    cmd.do_shift = st.out_free && !st.sp_full;
                    if (st.out_free && (st.sp_full || st.fin))
                        halted_next = 1'b1;
                end
                else if (st.cnt_max || st.rule_bad)
                begin
                    cmd.ev   = st.cnt_max ? EV_CHAIN : EV_NOENTRY;
                    cmd.emit = st.out_free;
                    if (st.out_free)
                        halted_next = 1'b1;
                end
                else
                    cmd.rd_rule = 1'b1;
            end
            ST_RULE:
            begin
                if (st.len_ge_sp)
                begin
                    cmd.ev   = EV_EMPTY;
                    cmd.emit = st.out_free;
                    if (st.out_free)
                        halted_next = 1'b1;
                end
                else
                    cmd.rd_base = 1'b1;
            end
            ST_BASE:
            begin
                if (st.lhs_bad || st.base_bad)
                begin
                    cmd.ev   = EV_NOENTRY;
                    cmd.emit = st.out_free;
                    if (st.out_free)
                        halted_next = 1'b1;
                end
                else
                    cmd.rd_goto = 1'b1;
            end
            ST_GOTO:
            begin
                if (!st.goto_valid)
                    cmd.ev = EV_NOENTRY;
                else if (st.red_ovf)
                    cmd.ev = EV_OVERFLOW;
                else
                    cmd.ev = EV_REDUCE;
                cmd.emit      = st.out_free;
                cmd.do_reduce = st.out_free && st.goto_valid && !st.red_ovf;
                if (st.out_free && (!st.goto_valid || st.red_ovf))
                    halted_next = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/lrpe_dpath.sv =====
// Parse tables, state stack, stack pointer and result register of the parse engine.
module lrpe_dpath
#(
    parameter int NUM_STATES       = lrpe_pkg::NUM_STATES_DEF,
    parameter int NUM_TERMINALS    = lrpe_pkg::NUM_TERMINALS_DEF,
    parameter int NUM_NONTERMINALS = lrpe_pkg::NUM_NONTERMINALS_DEF,
    parameter int NUM_RULES        = lrpe_pkg::NUM_RULES_DEF,
    parameter int STACK_DEPTH      = lrpe_pkg::STACK_DEPTH_DEF,
    parameter int MAX_REDUCTIONS   = lrpe_pkg::MAX_REDUCTIONS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  lrpe_pkg::lrpe_cmd_t    cmd,
    output lrpe_pkg::lrpe_status_t st,
    input  logic [2:0]             action,
    input  logic [7:0]             row,
    input  logic [5:0]             column,
    input  logic [1:0]             entry_kind,
    input  logic [7:0]             entry_value,
    input  logic [3:0]             rule_symbols,
    input  logic [5:0]             token,
    input  logic                   final_token,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [3:0]             event_res,
    output logic [7:0]             new_state,
    output logic [7:0]             rule_index,
    output logic [3:0]             popped,
    output logic                   last
);
    import lrpe_pkg::*;

    // Rows and columns beyond the field widths can never be addressed
    localparam int NS_E  = (NUM_STATES < 256) ? NUM_STATES : 256;
    localparam int NT_E  = (NUM_TERMINALS < 64) ? NUM_TERMINALS : 64;
    localparam int NN_E  = (NUM_NONTERMINALS < 256) ? NUM_NONTERMINALS : 256;
    localparam int NR_E  = (NUM_RULES < 256) ? NUM_RULES : 256;
    localparam int ST_D  = NS_E * NT_E;
    localparam int GT_D  = NS_E * NN_E;
    localparam int SAW   = (ST_D > 1) ? $clog2(ST_D) : 1;
    localparam int GAW   = (GT_D > 1) ? $clog2(GT_D) : 1;
    localparam int RAW   = (NR_E > 1) ? $clog2(NR_E) : 1;
    localparam int SIW   = $clog2(STACK_DEPTH);
    localparam int SPW   = $clog2(STACK_DEPTH + 1);
    localparam int CW    = $clog2(MAX_REDUCTIONS + 1);

    logic [8:0]  sh_mem   [ST_D];
    logic [9:0]  red_mem  [ST_D];
    logic [8:0]  goto_mem [GT_D];
    logic [11:0] rule_mem [NR_E];
    logic [7:0]  stk_mem  [STACK_DEPTH];

    logic [8:0]     sh_q, goto_q;
    logic [9:0]     red_q;
    logic [11:0]    rule_q;
    logic [7:0]     stk_q;
    logic [5:0]     tok_reg;
    logic           fin_reg;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [CW-1:0]  cnt_reg, cnt_next;

    logic           tab_ok, goto_ok, rule_ok;
    logic [SAW-1:0] tab_waddr, tab_raddr;
    logic [GAW-1:0] goto_waddr, goto_raddr;
    logic [RAW-1:0] rule_waddr, rule_raddr;
    logic [SIW-1:0] stk_raddr, stk_waddr;
    logic [7:0]     stk_wdata;
    logic           stk_we, stk_re;
    logic [3:0]     len;
    logic [7:0]     lhs;
    logic [31:0]    sp_minus_len;

    logic           ov_reg;
    lrpe_event_t    ev_reg;
    logic [7:0]     ns_reg, ri_reg;
    logic [3:0]     pop_reg;
    logic           last_reg;

    assign len          = rule_q[11:8];
    assign lhs          = rule_q[7:0];
    assign sp_minus_len = 32'(sp_reg) - 32'(len);

    // Load addresses and range checks
    assign tab_ok     = (32'(row) < NUM_STATES) && (32'(column) < NUM_TERMINALS);
    assign goto_ok    = (32'(row) < NUM_STATES) && (32'(column) < NUM_NONTERMINALS);
    assign rule_ok    = (32'(row) < NUM_RULES);
    assign tab_waddr  = SAW'(32'(row) * NT_E + 32'(column));
    assign goto_waddr = GAW'(32'(row) * NN_E + 32'(column));
    assign rule_waddr = RAW'(row);

    // Lookup addresses
    assign tab_raddr  = SAW'(32'(stk_q) * NT_E + 32'(tok_reg));
    assign goto_raddr = GAW'(32'(stk_q) * NN_E + 32'(lhs));
    assign rule_raddr = RAW'(red_q[7:0]);

    // Shift and reduce tables
    always_ff @(posedge clk)
    begin
        if (cmd.item_take && tab_ok && action == ACT_WR_SHIFT)
            sh_mem[tab_waddr] <= (entry_kind == KIND_VALUE) ? {1'b1, entry_value} : 9'd0;
        if (cmd.item_take && tab_ok && action == ACT_WR_RED)
            red_mem[tab_waddr] <= (entry_kind == KIND_VALUE || entry_kind == KIND_ACCEPT)
                                  ? {entry_kind, entry_value} : 10'd0;
        if (cmd.rd_tables)
        begin
            sh_q  <= sh_mem[tab_raddr];
            red_q <= red_mem[tab_raddr];
        end
    end

    // Goto table
    always_ff @(posedge clk)
    begin
        if (cmd.item_take && goto_ok && action == ACT_WR_GOTO)
            goto_mem[goto_waddr] <= (entry_kind == KIND_VALUE) ? {1'b1, entry_value} : 9'd0;
        if (cmd.rd_goto)
            goto_q <= goto_mem[goto_raddr];
    end

    // Rule table: right-side length and left-side nonterminal
    always_ff @(posedge clk)
    begin
        if (cmd.item_take && rule_ok && action == ACT_WR_RULE)
            rule_mem[rule_waddr] <= {rule_symbols, entry_value};
        if (cmd.rd_rule)
            rule_q <= rule_mem[rule_raddr];
    end

    // State stack: the bottom entry is never written and always reads as state zero
    assign stk_re    = cmd.rd_top || cmd.rd_base;
    assign stk_raddr = cmd.rd_top ? SIW'(32'(sp_reg) - 32'd1) : SIW'(sp_minus_len - 32'd1);
    assign stk_we    = cmd.do_shift || cmd.do_reduce;
    assign stk_waddr = cmd.do_shift ? SIW'(sp_reg) : SIW'(sp_minus_len);
    assign stk_wdata = cmd.do_shift ? sh_q[7:0] : goto_q[7:0];

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_waddr] <= stk_wdata;
        if (stk_re)
            stk_q <= (stk_raddr == '0) ? 8'd0 : stk_mem[stk_raddr];
    end

    // Token under work
    always_ff @(posedge clk)
    begin
        if (cmd.tok_load)
        begin
            tok_reg <= token;
            fin_reg <= final_token;
        end
    end

    // Stack pointer and reduction count
    always_comb
    begin
        sp_next  = sp_reg;
        cnt_next = cnt_reg;
        if (cmd.clr_stack)
            sp_next = SPW'(1);
        else if (cmd.do_shift)
            sp_next = sp_reg + SPW'(1);
        else if (cmd.do_reduce)
            sp_next = SPW'(sp_minus_len + 32'd1);
        if (cmd.tok_load)
            cnt_next = '0;
        else if (cmd.do_reduce)
            cnt_next = cnt_reg + CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg  <= SPW'(1);
            cnt_reg <= '0;
        end
        else
        begin
            sp_reg  <= sp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Status toward the controller
    always_comb
    begin
        st.tok_bad    = 32'(tok_reg) >= NUM_TERMINALS;
        st.top_bad    = 32'(stk_q) >= NUM_STATES;
        st.sh_valid   = sh_q[8];
        st.red_kind   = red_q[9:8];
        st.sp_full    = 32'(sp_reg) >= STACK_DEPTH;
        st.fin        = fin_reg;
        st.cnt_max    = 32'(cnt_reg) >= MAX_REDUCTIONS;
        st.rule_bad   = 32'(red_q[7:0]) >= NUM_RULES;
        st.len_ge_sp  = 32'(len) >= 32'(sp_reg);
        st.lhs_bad    = 32'(lhs) >= NUM_NONTERMINALS;
        st.base_bad   = 32'(stk_q) >= NUM_STATES;
        st.goto_valid = goto_q[8];
        st.red_ovf    = sp_minus_len >= 32'(STACK_DEPTH);
        st.out_free   = !ov_reg || out_ready;
    end

    // Result register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (cmd.emit)
            ov_reg <= 1'b1;
        else if (out_ready)
            ov_reg <= 1'b0;
    end

    // Result payload: fields that mean nothing for the event are zero
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            ev_reg   <= cmd.ev;
            ns_reg   <= 8'd0;
            ri_reg   <= 8'd0;
            pop_reg  <= 4'd0;
            last_reg <= 1'b1;
            case (cmd.ev)
                EV_SHIFT, EV_UNDERFLOW:
                    ns_reg <= sh_q[7:0];
                EV_CONFLICT:
                begin
                    ns_reg <= sh_q[7:0];
                    ri_reg <= red_q[7:0];
                end
                EV_REDUCE:
                begin
                    ns_reg   <= goto_q[7:0];
                    ri_reg   <= red_q[7:0];
                    pop_reg  <= len;
                    last_reg <= 1'b0;
                end
                default:
                    ns_reg <= 8'd0;
            endcase
        end
    end

    assign out_valid  = ov_reg;
    assign event_res  = ev_reg;
    assign new_state  = ns_reg;
    assign rule_index = ri_reg;
    assign popped     = pop_reg;
    assign last       = last_reg;

endmodule

// ===== rtl/lr_table_parse_engine_core.sv =====
// Top level of the table-driven LR parse engine.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | action row column entry_kind entry_value
//           |           |                      | rule_symbols token final_token
//   out     | output    | out_valid/out_ready  | event_res new_state rule_index popped last
//
// Load and start transactions are taken in the idle state. A token passes through
// stack read, table read and decision to its shift; each reduction adds another pass
// through the chain of single-port reads: stack top, tables, rule, stack base, goto.
// Reset leaves one stack entry holding state zero and parsing enabled; tables
// are undefined until loaded. A result waiting on out_ready stalls the sequencer.
module lr_table_parse_engine_core
#(
    parameter int NUM_STATES       = lrpe_pkg::NUM_STATES_DEF,
    parameter int NUM_TERMINALS    = lrpe_pkg::NUM_TERMINALS_DEF,
    parameter int NUM_NONTERMINALS = lrpe_pkg::NUM_NONTERMINALS_DEF,
    parameter int NUM_RULES        = lrpe_pkg::NUM_RULES_DEF,
    parameter int STACK_DEPTH      = lrpe_pkg::STACK_DEPTH_DEF,
    parameter int MAX_REDUCTIONS   = lrpe_pkg::MAX_REDUCTIONS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] action,
    input  logic [7:0] row,
    input  logic [5:0] column,
    input  logic [1:0] entry_kind,
    input  logic [7:0] entry_value,
    input  logic [3:0] rule_symbols,
    input  logic [5:0] token,
    input  logic       final_token,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] event_res,
    output logic [7:0] new_state,
    output logic [7:0] rule_index,
    output logic [3:0] popped,
    output logic       last
);
    import lrpe_pkg::*;

    lrpe_cmd_t    cmd;
    lrpe_status_t st;

    // Sequencer
    lrpe_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .st       (st),
        .cmd      (cmd)
    );

    // Tables, stack and result register
    lrpe_dpath
    #(
        .NUM_STATES       (NUM_STATES),
        .NUM_TERMINALS    (NUM_TERMINALS),
        .NUM_NONTERMINALS (NUM_NONTERMINALS),
        .NUM_RULES        (NUM_RULES),
        .STACK_DEPTH      (STACK_DEPTH),
        .MAX_REDUCTIONS   (MAX_REDUCTIONS)
    )
    u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .action       (action),
        .row          (row),
        .column       (column),
        .entry_kind   (entry_kind),
        .entry_value  (entry_value),
        .rule_symbols (rule_symbols),
        .token        (token),
        .final_token  (final_token),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_res    (event_res),
        .new_state    (new_state),
        .rule_index   (rule_index),
        .popped       (popped),
        .last         (last)
    );

endmodule

// ===== rtl/lrpe_checker.sv =====
// Port-level assertions for the parse engine core and their binding.
module lrpe_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] event_res,
    input logic [7:0] rule_index,
    input logic [3:0] popped,
    input logic       last
);
    import lrpe_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(last))
        else $error("stalled result changed");

    // Reductions never end a token
    a_reduce_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == EV_REDUCE |-> !last)
        else $error("reduce marked last");

    // Every other event ends a token
    a_other_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res != EV_REDUCE |-> last)
        else $error("final event not marked last");

    // Only reductions pop entries
    a_popped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res != EV_REDUCE |-> popped == 4'd0)
        else $error("pop count on non-reduce event");

    // A shift carries no rule
    a_shift_rule: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == EV_SHIFT |-> rule_index == 8'd0)
        else $error("rule index on shift");

endmodule

bind lr_table_parse_engine_core lrpe_checker u_lrpe_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_res  (event_res),
    .rule_index (rule_index),
    .popped     (popped),
    .last       (last)
);
